// ----- rtl/rmft_pkg.sv -----
// Package for the reference-counted MAC filter table.
// Holds sizes, status codes, the queued request type and the reserved-range check.
// No dependencies.
`default_nettype none
package rmft_pkg;

   localparam int unsigned TableSize = 256;
   localparam int unsigned IdxW      = $clog2(TableSize);
   localparam int unsigned AddrW     = 48;
   localparam int unsigned RefW      = 16;
   localparam logic [RefW-1:0] RefMax = '1;

   typedef enum logic [2:0] {
      ST_NEW    = 3'd0,
      ST_SHARED = 3'd1,
      ST_FULL   = 3'd2,
      ST_INVAL  = 3'd3,
      ST_FREED  = 3'd4,
      ST_DEC    = 3'd5
   } status_type;

   typedef enum logic {
      ACT_ALLOC  = 1'b0,
      ACT_REMOVE = 1'b1
   } action_type;

   typedef struct packed {
      action_type       action;
      logic [AddrW-1:0] mac_address;
      logic [AddrW-1:0] mac_mask;
      logic [IdxW-1:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic    valid;
      req_type req;
   } queue_out_type;

   typedef struct packed {
      logic [AddrW-1:0] addr;
      logic [AddrW-1:0] mask;
      logic [RefW-1:0]  refs;
   } entry_type;

   function automatic logic is_reserved(input logic [IdxW-1:0] i,
                                        input logic [7:0] rs,
                                        input logic [7:0] rc);
      logic [IdxW:0] lim;
      lim = {1'b0, IdxW'(rs)} + {1'b0, IdxW'(rc)};
      return (i != '0) && (i >= IdxW'(rs)) && ({1'b0, i} < lim);
   endfunction

endpackage
`default_nettype wire

// ----- rtl/rmft_front.sv -----
// Front end of the MAC filter table: accepts requests into a two-entry queue.
// Depends on rmft_pkg.
`default_nettype none
module rmft_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire rmft_pkg::req_type       req_item,
   input  wire                          pop,
   output rmft_pkg::queue_out_type      q_out
);
   rmft_pkg::req_type q_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, do_pop;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign do_pop    = pop && (cnt_ff != 2'd0);
   assign q_out.valid = (cnt_ff != 2'd0);
   assign q_out.req   = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = do_pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= req_item;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/rmft_engine.sv -----
// Back end of the MAC filter table: match scan, free scan, entry memory, result register.
// Depends on rmft_pkg.
`default_nettype none
module rmft_engine (
   input  wire                          clock,
   input  wire                          reset,
   input  wire rmft_pkg::queue_out_type q_in,
   output logic                         pop,
   input  wire [7:0]                    rsv_start,
   input  wire [7:0]                    rsv_count,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [2:0]                   rsp_status,
   output logic [rmft_pkg::IdxW-1:0]    rsp_result_index,
   output logic [rmft_pkg::RefW-1:0]    rsp_ref_count,
   output logic                         rsp_table_full
);
   localparam int unsigned IW = rmft_pkg::IdxW;
   localparam int unsigned RW = rmft_pkg::RefW;
   localparam int unsigned AW = rmft_pkg::AddrW;
   localparam logic [IW-1:0] LastIdx = IW'(rmft_pkg::TableSize - 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_REM   = 5'b00100,
      S_HIT   = 5'b01000,
      S_FSCAN = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      FP_PRE  = 2'd0,
      FP_POST = 2'd1,
      FP_FREE = 2'd2
   } purpose_type;

   rmft_pkg::entry_type mem [rmft_pkg::TableSize];
   rmft_pkg::entry_type rd_q_ff, d;
   logic [IW-1:0]       rd_idx_ff, rd_addr;
   logic                we;
   logic [IW-1:0]       wa;
   rmft_pkg::entry_type wd;

   state_type   st_ff, st_in;
   purpose_type pur_ff, pur_in;
   logic [rmft_pkg::TableSize-1:0] used_ff, used_in;
   logic          e0w_ff, e0w_in, full_ff, full_in;
   logic [IW-1:0] nf_ff, nf_in, fp_ff, fp_in, k_ff, k_in;
   logic [IW:0]   scan_ff, scan_in;
   logic [IW-1:0] cmp_ff, cmp_in, idx_ff, idx_in;
   logic          cmpv_ff, cmpv_in;
   logic [AW-1:0] addr_ff, addr_in, mask_ff, mask_in;
   logic [RW-1:0] refs_ff, refs_in;
   logic          rv_ff, rv_in, ofull_ff, ofull_in;
   logic [2:0]    ost_ff, ost_in;
   logic [IW-1:0] oidx_ff, oidx_in;
   logic [RW-1:0] oref_ff, oref_in;
   logic          emit, free_now, match;
   logic [RW-1:0] refs_new;

   assign d = (rd_idx_ff == '0 && !e0w_ff) ? '0 : rd_q_ff;
   assign free_now = !used_ff[fp_ff] && !rmft_pkg::is_reserved(fp_ff, rsv_start, rsv_count);
   assign match = used_ff[cmp_ff] && !rmft_pkg::is_reserved(cmp_ff, rsv_start, rsv_count)
                  && d.addr == addr_ff && d.mask == mask_ff;
   assign refs_new = (refs_ff == rmft_pkg::RefMax) ? refs_ff : refs_ff + 1'b1;

   always_comb begin
      st_in = st_ff;   pur_in = pur_ff;  used_in = used_ff;
      e0w_in = e0w_ff; full_in = full_ff; nf_in = nf_ff;
      fp_in = fp_ff;   k_in = k_ff;       scan_in = scan_ff;
      cmp_in = cmp_ff; cmpv_in = 1'b0;    idx_in = idx_ff;
      addr_in = addr_ff; mask_in = mask_ff; refs_in = refs_ff;
      rd_addr = scan_ff[IW-1:0];
      we = 1'b0; wa = idx_ff; wd = '0;
      pop = 1'b0; emit = 1'b0;
      ost_in = ost_ff; oidx_in = oidx_ff; oref_in = oref_ff;
      rv_in = rv_ff && rsp_stall;

      unique case (st_ff)
         S_IDLE: begin
            if (q_in.valid && !rv_ff) begin
               pop     = 1'b1;
               addr_in = q_in.req.mac_address;
               mask_in = q_in.req.mac_mask;
               idx_in  = q_in.req.entry_index;
               if (q_in.req.action == rmft_pkg::ACT_ALLOC) begin
                  scan_in = '0;
                  st_in   = S_SCAN;
               end else begin
                  rd_addr = q_in.req.entry_index;
                  st_in   = S_REM;
               end
            end
         end
         S_SCAN: begin
            if (!scan_ff[IW]) begin
               cmp_in  = scan_ff[IW-1:0];
               cmpv_in = 1'b1;
               scan_in = scan_ff + 1'b1;
            end
            if (cmpv_ff) begin
               if (match) begin
                  idx_in  = cmp_ff;
                  refs_in = d.refs;
                  st_in   = S_HIT;
               end else if (cmp_ff == LastIdx) begin
                  if (full_ff) begin
                     emit = 1'b1;
                     ost_in = rmft_pkg::ST_FULL; oidx_in = '0; oref_in = '0;
                  end else begin
                     fp_in = nf_ff; k_in = '0; pur_in = FP_PRE; st_in = S_FSCAN;
                  end
               end
            end
         end
         S_HIT: begin
            we = 1'b1; wa = idx_ff; wd = '{addr: addr_ff, mask: mask_ff, refs: refs_new};
            if (idx_ff == '0) e0w_in = 1'b1;
            emit = 1'b1;
            ost_in = rmft_pkg::ST_SHARED; oidx_in = idx_ff; oref_in = refs_new;
         end
         S_REM: begin
            if (rmft_pkg::is_reserved(idx_ff, rsv_start, rsv_count) || !used_ff[idx_ff]
                || d.refs == '0) begin
               emit = 1'b1;
               ost_in = rmft_pkg::ST_INVAL; oidx_in = idx_ff; oref_in = '0;
            end else if (d.refs == RW'(1)) begin
               used_in[idx_ff] = 1'b0;
               full_in = 1'b0;
               fp_in = nf_ff; k_in = '0; pur_in = FP_FREE; st_in = S_FSCAN;
            end else begin
               we = 1'b1; wa = idx_ff;
               wd = '{addr: d.addr, mask: d.mask, refs: d.refs - 1'b1};
               emit = 1'b1;
               ost_in = rmft_pkg::ST_DEC; oidx_in = idx_ff; oref_in = d.refs - 1'b1;
            end
         end
         S_FSCAN: begin
            if (free_now) begin
               nf_in = fp_ff;
               unique case (pur_ff)
                  FP_PRE: begin
                     we = 1'b1; wa = fp_ff;
                     wd = '{addr: addr_ff, mask: mask_ff, refs: RW'(1)};
                     used_in[fp_ff] = 1'b1;
                     if (fp_ff == '0) e0w_in = 1'b1;
                     idx_in = fp_ff; k_in = '0; pur_in = FP_POST;
                  end
                  FP_POST: begin
                     emit = 1'b1;
                     ost_in = rmft_pkg::ST_NEW; oidx_in = idx_ff; oref_in = RW'(1);
                  end
                  default: begin
                     emit = 1'b1;
                     ost_in = rmft_pkg::ST_FREED; oidx_in = idx_ff; oref_in = '0;
                  end
               endcase
            end else if (k_ff == LastIdx) begin
               emit = 1'b1;
               unique case (pur_ff)
                  FP_PRE: begin
                     full_in = 1'b1;
                     ost_in = rmft_pkg::ST_FULL; oidx_in = '0; oref_in = '0;
                  end
                  FP_POST: begin
                     full_in = 1'b1;
                     ost_in = rmft_pkg::ST_NEW; oidx_in = idx_ff; oref_in = RW'(1);
                  end
                  default: begin
                     ost_in = rmft_pkg::ST_FREED; oidx_in = idx_ff; oref_in = '0;
                  end
               endcase
            end else begin
               fp_in = fp_ff + 1'b1;
               k_in  = k_ff + 1'b1;
            end
         end
         default: st_in = S_IDLE;
      endcase

      if (emit) begin
         rv_in = 1'b1;
         st_in = S_IDLE;
      end
      ofull_in = emit ? full_in : ofull_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         used_ff <= {{(rmft_pkg::TableSize-1){1'b0}}, 1'b1};
         e0w_ff  <= 1'b0;
         full_ff <= 1'b0;
         nf_ff   <= IW'(1);
         rv_ff   <= 1'b0;
         cmpv_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         used_ff <= used_in;
         e0w_ff  <= e0w_in;
         full_ff <= full_in;
         nf_ff   <= nf_in;
         rv_ff   <= rv_in;
         cmpv_ff <= cmpv_in;
      end
   end

   always_ff @(posedge clock) begin
      pur_ff <= pur_in;   fp_ff <= fp_in;     k_ff <= k_in;
      scan_ff <= scan_in; cmp_ff <= cmp_in;   idx_ff <= idx_in;
      addr_ff <= addr_in; mask_ff <= mask_in; refs_ff <= refs_in;
      ost_ff <= ost_in;   oidx_ff <= oidx_in; oref_ff <= oref_in;
      ofull_ff <= ofull_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_q_ff   <= mem[rd_addr];
      rd_idx_ff <= rd_addr;
   end

   assign rsp_valid        = rv_ff;
   assign rsp_status       = ost_ff;
   assign rsp_result_index = oidx_ff;
   assign rsp_ref_count    = oref_ff;
   assign rsp_table_full   = ofull_ff;
endmodule
`default_nettype wire

// ----- rtl/refcounted_mac_filter_table.sv -----
// Reference-counted MAC address/mask filter table, top level.
// Request channel: req_valid/req_stall with action, address, mask and entry index.
// Result channel: rsp_valid/rsp_stall, one result per request, in order.
// Configuration: csr_valid/csr_ready (always ready), csr_index 0 writes the
// reserved range start, 1 writes the reserved range count; write only while idle.
// Requests enter a two-entry queue, so up to two can wait while a result is held.
// Operation: an allocate scans the entries through the entry memory, one per
// cycle, up to the first match or the last entry; on a miss when not full, a
// circular free scan over the used bits finds a free entry before the write and
// the next free entry after it. A remove reads the entry, and runs the free scan
// when it frees the entry. The engine works on one request at a time.
// Reset (synchronous): empty queue, entry 0 used with no references, all other
// entries unused, next free index 1, not full, reserved range empty.
// While rsp_stall is high the result holds, and no new request starts execution while a result is held.
`default_nettype none
module refcounted_mac_filter_table (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire         req_action,
   input  wire  [47:0] req_mac_address,
   input  wire  [47:0] req_mac_mask,
   input  wire  [7:0]  req_entry_index,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_result_index,
   output logic [15:0] rsp_ref_count,
   output logic        rsp_table_full,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire         csr_index,
   input  wire  [7:0]  csr_wdata
);
   rmft_pkg::req_type       req_item;
   rmft_pkg::queue_out_type q_out;
   logic                    pop;
   logic [7:0]              rs_ff, rs_in, rc_ff, rc_in;

   assign csr_ready = 1'b1;
   assign req_item.action      = rmft_pkg::action_type'(req_action);
   assign req_item.mac_address = req_mac_address;
   assign req_item.mac_mask    = req_mac_mask;
   assign req_item.entry_index = req_entry_index;

   always_comb begin
      rs_in = rs_ff;
      rc_in = rc_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == 1'b0) rs_in = csr_wdata;
         else rc_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_ff <= '0;
         rc_ff <= '0;
      end else begin
         rs_ff <= rs_in;
         rc_ff <= rc_in;
      end
   end

   rmft_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .pop       (pop),
      .q_out     (q_out)
   );

   rmft_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .q_in             (q_out),
      .pop              (pop),
      .rsv_start        (rs_ff),
      .rsv_count        (rc_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_result_index (rsp_result_index),
      .rsp_ref_count    (rsp_ref_count),
      .rsp_table_full   (rsp_table_full)
   );

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rmft_pkg::ST_FULL |-> rsp_table_full)
      else $error("full status without full flag");
   a_freed_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rmft_pkg::ST_FREED |-> !rsp_table_full && rsp_ref_count == 0)
      else $error("freed entry reported wrongly");
   a_new_one_ref: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rmft_pkg::ST_NEW |-> rsp_ref_count == 16'd1)
      else $error("new entry without single reference");
endmodule
`default_nettype wire

// ----- dv/rmft_scoreboard.sv -----
// Scoreboard for the reference-counted MAC filter table: watches the request,
// result and register channels, predicts each result and compares it in order.
// Depends on rmft_pkg for status and action codes.
module rmft_scoreboard (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   input  wire         req_stall,
   input  wire         req_action,
   input  wire  [47:0] req_mac_address,
   input  wire  [47:0] req_mac_mask,
   input  wire  [7:0]  req_entry_index,
   input  wire         rsp_valid,
   input  wire         rsp_stall,
   input  wire  [2:0]  rsp_status,
   input  wire  [7:0]  rsp_result_index,
   input  wire  [15:0] rsp_ref_count,
   input  wire         rsp_table_full,
   input  wire         csr_valid,
   input  wire         csr_ready,
   input  wire         csr_index,
   input  wire  [7:0]  csr_wdata,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      rmft_pkg::status_type status;
      logic [7:0]           index;
      logic [15:0]          refs;
      logic                 full;
   } table_result_type;

   logic [47:0] tbl_addr [rmft_pkg::TableSize];
   logic [47:0] tbl_mask [rmft_pkg::TableSize];
   logic [15:0] tbl_refs [rmft_pkg::TableSize];
   logic        tbl_used [rmft_pkg::TableSize];
   int          free_ptr;
   logic        is_full;
   int          rsv_start;
   int          rsv_count;
   table_result_type result_queue[$];

   function automatic bit in_rsv_range(int i);
      return i != 0 && i >= rsv_start && i < rsv_start + rsv_count;
   endfunction

   function automatic bit entry_free(int i);
      return !tbl_used[i] && !in_rsv_range(i);
   endfunction

   function automatic bit find_free();
      int i;
      if (free_ptr >= rmft_pkg::TableSize) free_ptr = 0;
      if (entry_free(free_ptr)) return 1;
      i = free_ptr;
      for (int k = 1; k < rmft_pkg::TableSize; k++) begin
         i = (i + 1 >= rmft_pkg::TableSize) ? 0 : i + 1;
         if (entry_free(i)) begin
            free_ptr = i;
            return 1;
         end
      end
      return 0;
   endfunction

   function automatic table_result_type apply_request(logic act, logic [47:0] addr,
                                                      logic [47:0] mask, logic [7:0] ei);
      table_result_type r;
      int hit_at;
      r.index = '0;
      r.refs = '0;
      hit_at = -1;
      if (act == rmft_pkg::ACT_ALLOC) begin
         for (int i = 0; i < rmft_pkg::TableSize; i++) begin
            if (tbl_used[i] && !in_rsv_range(i) && tbl_addr[i] == addr &&
                tbl_mask[i] == mask) begin
               hit_at = i;
               break;
            end
         end
         if (hit_at >= 0) begin
            if (tbl_refs[hit_at] != rmft_pkg::RefMax) tbl_refs[hit_at]++;
            r.status = rmft_pkg::ST_SHARED;
            r.index = hit_at[7:0];
            r.refs = tbl_refs[hit_at];
         end else if (is_full || !find_free()) begin
            is_full = 1'b1;
            r.status = rmft_pkg::ST_FULL;
         end else begin
            tbl_addr[free_ptr] = addr;
            tbl_mask[free_ptr] = mask;
            tbl_refs[free_ptr] = 16'd1;
            tbl_used[free_ptr] = 1'b1;
            r.index = free_ptr[7:0];
            r.refs = 16'd1;
            r.status = rmft_pkg::ST_NEW;
            if (!find_free()) is_full = 1'b1;
         end
      end else begin
         r.index = ei;
         if (in_rsv_range(ei) || !tbl_used[ei] || tbl_refs[ei] == 0) begin
            r.status = rmft_pkg::ST_INVAL;
         end else if (tbl_refs[ei] == 16'd1) begin
            tbl_addr[ei] = '0;
            tbl_mask[ei] = '0;
            tbl_refs[ei] = '0;
            tbl_used[ei] = 1'b0;
            is_full = 1'b0;
            void'(find_free());
            r.status = rmft_pkg::ST_FREED;
         end else begin
            tbl_refs[ei]--;
            r.refs = tbl_refs[ei];
            r.status = rmft_pkg::ST_DEC;
         end
      end
      r.full = is_full;
      return r;
   endfunction

   assign pending = result_queue.size();

   always @(posedge clock) begin
      table_result_type want;
      if (reset) begin
         for (int i = 0; i < rmft_pkg::TableSize; i++) begin
            tbl_addr[i] = '0;
            tbl_mask[i] = '0;
            tbl_refs[i] = '0;
            tbl_used[i] = (i == 0);
         end
         free_ptr = 1;
         is_full = 1'b0;
         rsv_start = 0;
         rsv_count = 0;
         result_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == 1'b0) rsv_start = csr_wdata;
            else rsv_count = csr_wdata;
         end
         if (req_valid && !req_stall)
            result_queue.push_back(apply_request(req_action, req_mac_address,
                                                 req_mac_mask, req_entry_index));
         if (rsp_valid && !rsp_stall) begin
            if (result_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: status %0d index %0d refs %0d full %0b",
                           rsp_status, rsp_result_index, rsp_ref_count, rsp_table_full);
            end else begin
               want = result_queue.pop_front();
               if (rsp_status !== want.status || rsp_result_index !== want.index ||
                   rsp_ref_count !== want.refs || rsp_table_full !== want.full) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                              want.status, want.index, want.refs, want.full,
                              rsp_status, rsp_result_index, rsp_ref_count,
                              rsp_table_full);
               end
            end
         end
      end
   end

   initial fail_count = 0;

endmodule

// ----- dv/tb_refcounted_mac_filter_table.sv -----
// Top of the MAC filter table testbench: clock, reset, requests, register
// writes and result stalls, with the verdict taken from rmft_scoreboard.
// Depends on rmft_pkg, refcounted_mac_filter_table and rmft_scoreboard.
module tb_refcounted_mac_filter_table;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = rmft_pkg::ACT_ALLOC;
   logic [47:0] req_mac_address = '0;
   logic [47:0] req_mac_mask = '0;
   logic [7:0]  req_entry_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_result_index;
   logic [15:0] rsp_ref_count;
   logic        rsp_table_full;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [7:0]  csr_wdata = '0;
   int          fail_count;
   int          pending;

   int          idle_pct = 0;
   int          stall_pct = 0;
   int          hold_left = 0;
   bit          hold_now = 0;
   logic [47:0] pair_addr [12];
   logic [47:0] pair_mask [12];

   refcounted_mac_filter_table i_dut (.*);
   rmft_scoreboard i_scoreboard (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_now && hold_left == 0) hold_left <= 3000;
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_request(logic act, logic [47:0] addr, logic [47:0] mask,
                               logic [7:0] ei);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_mac_address <= addr;
      req_mac_mask <= mask;
      req_entry_index <= ei;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (800) @(posedge clock);
   endtask

   task automatic write_reg(logic [7:0] start, logic [7:0] count);
      csr_valid <= 1'b1;
      csr_index <= 1'b0;
      csr_wdata <= start;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_index <= 1'b1;
      csr_wdata <= count;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_request();
      int pick;
      int p;
      pick = $urandom_range(99);
      p = $urandom_range(11);
      if (pick < 55)
         send_request(rmft_pkg::ACT_ALLOC, pair_addr[p], pair_mask[p], 8'($urandom));
      else if (pick < 65)
         send_request(rmft_pkg::ACT_ALLOC, {16'($urandom), 32'($urandom)},
                      {16'($urandom), 32'($urandom)}, 8'($urandom));
      else if (pick < 92)
         send_request(rmft_pkg::ACT_REMOVE, {16'($urandom), 32'($urandom)},
                      {16'($urandom), 32'($urandom)}, 8'($urandom_range(0, 16)));
      else
         send_request(rmft_pkg::ACT_REMOVE, '0, '0, 8'($urandom));
   endtask

   initial begin
      int rs [6] = '{0, 1, 200, 255, 250, 0};
      int rc [6] = '{0, 250, 255, 255, 5, 4};
      int ip [6] = '{0, 53, 0, 36, 53, 0};
      int sp [6] = '{0, 0, 53, 36, 53, 0};
      pair_addr[0] = '0;
      pair_mask[0] = '0;
      pair_addr[1] = '1;
      pair_mask[1] = '1;
      for (int i = 2; i < 12; i++) begin
         pair_addr[i] = {16'($urandom), 32'($urandom)};
         pair_mask[i] = {16'($urandom), 32'($urandom)};
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(rmft_pkg::ACT_REMOVE, '0, '0, 8'd0);
      send_request(rmft_pkg::ACT_ALLOC, '0, '0, 8'd0);
      send_request(rmft_pkg::ACT_ALLOC, '0, '0, 8'd0);
      send_request(rmft_pkg::ACT_REMOVE, '1, '1, 8'd0);
      send_request(rmft_pkg::ACT_REMOVE, '0, '0, 8'd0);
      send_request(rmft_pkg::ACT_REMOVE, '0, '0, 8'd0);
      send_request(rmft_pkg::ACT_ALLOC, '1, '1, 8'hff);
      send_request(rmft_pkg::ACT_ALLOC, '1, '1, 8'd0);
      send_request(rmft_pkg::ACT_ALLOC, '1, '0, 8'd0);
      send_request(rmft_pkg::ACT_ALLOC, '0, '1, 8'd0);
      send_request(rmft_pkg::ACT_ALLOC, '0, '0, 8'd0);
      send_request(rmft_pkg::ACT_REMOVE, '0, '0, 8'd1);
      send_request(rmft_pkg::ACT_REMOVE, '0, '0, 8'd1);
      send_request(rmft_pkg::ACT_REMOVE, '0, '0, 8'd1);
      send_request(rmft_pkg::ACT_REMOVE, '0, '0, 8'd255);
      send_request(rmft_pkg::ACT_REMOVE, '0, '0, 8'd200);
      wait_drained();
      write_reg(8'd1, 8'd3);
      send_request(rmft_pkg::ACT_REMOVE, '0, '0, 8'd2);
      send_request(rmft_pkg::ACT_ALLOC, '0, '1, 8'd0);
      send_request(rmft_pkg::ACT_ALLOC, '1, '0, 8'd0);
      send_request(rmft_pkg::ACT_REMOVE, '0, '0, 8'd4);
      wait_drained();

      for (int ph = 0; ph < 6; ph++) begin
         write_reg(8'(rs[ph]), 8'(rc[ph]));
         idle_pct = ip[ph];
         stall_pct = sp[ph];
         hold_now = (ph == 2);
         for (int n = 0; n < 192; n++) random_request();
         hold_now = 0;
         wait_drained();
      end

      if (fail_count == 0)
         $display("refcounted_mac_filter_table verification clean");
      else
         $display("refcounted_mac_filter_table verification failed");
      $finish;
   end

   initial begin
      #100ms;
      $display("refcounted_mac_filter_table verification failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/rmft_pkg.sv
rtl/rmft_front.sv
rtl/rmft_engine.sv
rtl/refcounted_mac_filter_table.sv
dv/rmft_scoreboard.sv
dv/tb_refcounted_mac_filter_table.sv
